// File: rtl/sc2d_pkg.sv
// sc2d_pkg: constants, tables and keycode helpers for the set 2 scan code decoder
// no dependencies; used by the interfaces and by scan_code_set2_decoder
package sc2d_pkg;

  // store depth for one sequence
  localparam int SEQ_DEPTH = 8;
  localparam int SEQ_IDX_W = $clog2(SEQ_DEPTH);
  localparam int SEQ_LEN_W = 4;
  localparam int NEED_W    = 3;

  // field widths
  localparam int BYTE_W = 8;
  localparam int KC_W   = 7;

  typedef logic [BYTE_W-1:0] scan_byte_t;
  typedef logic [KC_W-1:0]   key_code_t;

  // prefix and special bytes
  localparam scan_byte_t CODE_EXT    = 8'he0;
  localparam scan_byte_t CODE_BREAK  = 8'hf0;
  localparam scan_byte_t CODE_PAUSE  = 8'he1;
  localparam scan_byte_t CODE_PRT_A  = 8'h12;
  localparam scan_byte_t CODE_PRT_B  = 8'h7c;

  // keycodes with a fixed meaning
  localparam key_code_t KC_UNKNOWN      = 7'd0;
  localparam key_code_t KC_PRINT_SCREEN = 7'd105;
  localparam key_code_t KC_PAUSE        = 7'd106;

  // sequence lengths that close on a named pattern
  localparam logic [SEQ_LEN_W-1:0] LEN_SINGLE    = 4'd1;
  localparam logic [SEQ_LEN_W-1:0] LEN_PREFIXED  = 4'd2;
  localparam logic [SEQ_LEN_W-1:0] LEN_EXT_BREAK = 4'd3;
  localparam logic [SEQ_LEN_W-1:0] LEN_PRT_MAKE  = 4'd4;
  localparam logic [SEQ_LEN_W-1:0] LEN_PRT_BREAK = 4'd6;
  localparam logic [SEQ_LEN_W-1:0] LEN_PAUSE     = 4'd8;

  // fixed byte patterns
  localparam scan_byte_t PRT_MAKE_PAT [4] = '{8'he0, 8'h12, 8'he0, 8'h7c};
  localparam scan_byte_t PRT_BREAK_PAT [6] =
    '{8'he0, 8'hf0, 8'h7c, 8'he0, 8'hf0, 8'h12};
  localparam scan_byte_t PAUSE_PAT [8] =
    '{8'he1, 8'h14, 8'h77, 8'he1, 8'hf0, 8'h14, 8'hf0, 8'h77};

  // single-byte keycode table, codes 0x00 to 0x87
  localparam int SINGLE_SIZE = 136;
  localparam key_code_t SINGLE_MAP [SINGLE_SIZE] = '{
    7'd0,  7'd69, 7'd0,  7'd65, 7'd63, 7'd61, 7'd62, 7'd72,
    7'd0,  7'd70, 7'd68, 7'd66, 7'd64, 7'd50, 7'd37, 7'd0,
    7'd0,  7'd54, 7'd52, 7'd0,  7'd53, 7'd17, 7'd28, 7'd0,
    7'd0,  7'd0,  7'd26, 7'd19, 7'd1,  7'd23, 7'd29, 7'd0,
    7'd0,  7'd3,  7'd24, 7'd4,  7'd5,  7'd31, 7'd30, 7'd0,
    7'd0,  7'd49, 7'd22, 7'd6,  7'd20, 7'd18, 7'd32, 7'd0,
    7'd0,  7'd14, 7'd2,  7'd8,  7'd7,  7'd25, 7'd33, 7'd0,
    7'd0,  7'd0,  7'd13, 7'd10, 7'd21, 7'd34, 7'd35, 7'd0,
    7'd0,  7'd45, 7'd11, 7'd9,  7'd15, 7'd27, 7'd36, 7'd0,
    7'd0,  7'd46, 7'd47, 7'd12, 7'd43, 7'd16, 7'd38, 7'd0,
    7'd0,  7'd0,  7'd44, 7'd0,  7'd41, 7'd39, 7'd0,  7'd0,
    7'd51, 7'd60, 7'd55, 7'd42, 7'd0,  7'd40, 7'd0,  7'd0,
    7'd0,  7'd59, 7'd0,  7'd0,  7'd0,  7'd0,  7'd48, 7'd0,
    7'd0,  7'd79, 7'd0,  7'd82, 7'd85, 7'd0,  7'd0,  7'd0,
    7'd78, 7'd77, 7'd80, 7'd83, 7'd84, 7'd86, 7'd56, 7'd58,
    7'd71, 7'd76, 7'd81, 7'd74, 7'd73, 7'd87, 7'd57, 7'd0,
    7'd0,  7'd0,  7'd0,  7'd67, 7'd0,  7'd0,  7'd0,  7'd0
  };

  // keycode of a plain byte, unknown above the table
  function automatic key_code_t map_single(input scan_byte_t b);
    key_code_t kc;
    kc = KC_UNKNOWN;
    if (b < scan_byte_t'(SINGLE_SIZE)) begin
      kc = SINGLE_MAP[b];
    end
    return kc;
  endfunction

  // keycode of the byte after an E0 prefix
  function automatic key_code_t map_extended(input scan_byte_t b);
    key_code_t kc;
    unique case (b)
      8'h1f:   kc = 7'd88;
      8'h14:   kc = 7'd89;
      8'h27:   kc = 7'd90;
      8'h11:   kc = 7'd91;
      8'h2f:   kc = 7'd92;
      8'h70:   kc = 7'd93;
      8'h6c:   kc = 7'd94;
      8'h7d:   kc = 7'd95;
      8'h71:   kc = 7'd96;
      8'h69:   kc = 7'd97;
      8'h7a:   kc = 7'd98;
      8'h75:   kc = 7'd99;
      8'h6b:   kc = 7'd100;
      8'h72:   kc = 7'd101;
      8'h74:   kc = 7'd102;
      8'h4a:   kc = 7'd103;
      8'h5a:   kc = 7'd104;
      default: kc = KC_UNKNOWN;
    endcase
    return kc;
  endfunction

endpackage

// File: rtl/sc2d_if.sv
// sc2d_if: valid/ready channels for received scan bytes and decoded keys
// depends on sc2d_pkg for the payload types
interface sc2d_byte_if;
  logic                valid;
  logic                ready;
  sc2d_pkg::scan_byte_t scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface sc2d_key_if;
  logic               valid;
  logic               ready;
  sc2d_pkg::key_code_t key_code;
  logic               released;
  logic               pattern_mismatch;

  modport source (output valid, output key_code, output released,
                  output pattern_mismatch, input ready);
  modport sink   (input valid, input key_code, input released,
                  input pattern_mismatch, output ready);
endinterface

// File: rtl/scan_code_set2_decoder.sv
// scan_code_set2_decoder: collects set 2 scan byte sequences into keycodes
// depends on sc2d_pkg and the channel interfaces in sc2d_if.sv
//
//   channel  dir  modport  payload
//   scan     in   sink     scan_byte[7:0]
//   key      out  source   key_code[6:0], released, pattern_mismatch
//
// one byte a cycle while scan.ready is high; a request that closes a sequence
// shows its key in the output register in the cycle after it is accepted; the
// byte decode and table lookup ahead of that register are combinational.
// synchronous rst clears the collect state and the output valid.
// scan.ready drops only while a key waits and key.ready is low.
module scan_code_set2_decoder (
  input  logic         clk,
  input  logic         rst,
  sc2d_byte_if.sink    scan,
  sc2d_key_if.source   key
);

  // sequence state
  logic                                collecting;
  logic [sc2d_pkg::SEQ_LEN_W-1:0]      seq_length;
  logic [sc2d_pkg::NEED_W-1:0]         bytes_needed;
  sc2d_pkg::scan_byte_t                seq_bytes [sc2d_pkg::SEQ_DEPTH];

  // output register
  logic                 out_valid;
  sc2d_pkg::key_code_t  out_code;
  logic                 out_rel;
  logic                 out_bad;

  // per-request decode
  logic                                accept;
  logic [sc2d_pkg::SEQ_LEN_W-1:0]      cur_len;
  logic [sc2d_pkg::SEQ_LEN_W-1:0]      len_next;
  logic [sc2d_pkg::SEQ_IDX_W-1:0]      wr_pos;
  logic [sc2d_pkg::NEED_W-1:0]         need_next;
  logic                                done;
  sc2d_pkg::scan_byte_t                view [sc2d_pkg::SEQ_DEPTH];
  sc2d_pkg::key_code_t                 kc_next;
  logic                                rel_next;
  logic                                bad_next;

  assign scan.ready = !out_valid || key.ready;
  assign accept     = scan.valid && scan.ready;

  // write position and new length
  assign cur_len  = collecting ? seq_length : '0;
  assign wr_pos   = cur_len[sc2d_pkg::SEQ_IDX_W-1:0];
  assign len_next = cur_len + 4'd1;

  // sequence as it stands with the new byte in place
  always_comb begin
    for (int i = 0; i < sc2d_pkg::SEQ_DEPTH; i++) begin
      view[i] = (wr_pos == sc2d_pkg::SEQ_IDX_W'(i)) ? scan.scan_byte : seq_bytes[i];
    end
  end

  // bytes still wanted after this one
  always_comb begin
    need_next = '0;
    if (!collecting) begin
      if (scan.scan_byte == sc2d_pkg::CODE_EXT || scan.scan_byte == sc2d_pkg::CODE_BREAK) begin
        need_next = 3'd1;
      end else if (scan.scan_byte == sc2d_pkg::CODE_PAUSE) begin
        need_next = 3'd7;
      end
    end else begin
      need_next = bytes_needed - 3'd1;
      if (len_next == sc2d_pkg::LEN_PREFIXED && view[0] == sc2d_pkg::CODE_EXT) begin
        if (scan.scan_byte == sc2d_pkg::CODE_PRT_A) begin
          need_next = 3'd2;
        end else if (scan.scan_byte == sc2d_pkg::CODE_BREAK) begin
          need_next = 3'd1;
        end
      end else if (len_next == sc2d_pkg::LEN_EXT_BREAK
                   && scan.scan_byte == sc2d_pkg::CODE_PRT_B) begin
        need_next = 3'd3;
      end
    end
  end

  assign done = (need_next == '0) || (len_next >= sc2d_pkg::LEN_PAUSE);

  // translate the closed sequence
  always_comb begin
    kc_next  = sc2d_pkg::KC_UNKNOWN;
    rel_next = 1'b0;
    bad_next = 1'b0;
    unique case (len_next)
      sc2d_pkg::LEN_SINGLE: begin
        kc_next = sc2d_pkg::map_single(scan.scan_byte);
      end
      sc2d_pkg::LEN_PREFIXED: begin
        if (view[0] == sc2d_pkg::CODE_EXT) begin
          kc_next = sc2d_pkg::map_extended(scan.scan_byte);
        end else begin
          kc_next  = sc2d_pkg::map_single(scan.scan_byte);
          rel_next = 1'b1;
        end
      end
      sc2d_pkg::LEN_EXT_BREAK: begin
        kc_next  = sc2d_pkg::map_extended(scan.scan_byte);
        rel_next = 1'b1;
      end
      sc2d_pkg::LEN_PRT_MAKE: begin
        kc_next = sc2d_pkg::KC_PRINT_SCREEN;
        for (int i = 0; i < 4; i++) begin
          if (view[i] != sc2d_pkg::PRT_MAKE_PAT[i]) bad_next = 1'b1;
        end
      end
      sc2d_pkg::LEN_PRT_BREAK: begin
        kc_next  = sc2d_pkg::KC_PRINT_SCREEN;
        rel_next = 1'b1;
        for (int i = 0; i < 6; i++) begin
          if (view[i] != sc2d_pkg::PRT_BREAK_PAT[i]) bad_next = 1'b1;
        end
      end
      sc2d_pkg::LEN_PAUSE: begin
        kc_next = sc2d_pkg::KC_PAUSE;
        for (int i = 0; i < 8; i++) begin
          if (view[i] != sc2d_pkg::PAUSE_PAT[i]) bad_next = 1'b1;
        end
      end
      default: begin
        kc_next = sc2d_pkg::KC_UNKNOWN;
      end
    endcase
  end

  // sequence store, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_bytes[wr_pos] <= scan.scan_byte;
    end
  end

  // collect state
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting   <= 1'b0;
      seq_length   <= '0;
      bytes_needed <= '0;
    end else if (accept) begin
      seq_length   <= len_next;
      collecting   <= !done;
      bytes_needed <= done ? '0 : need_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && done) begin
      out_valid <= 1'b1;
    end else if (key.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      out_code <= kc_next;
      out_rel  <= rel_next;
      out_bad  <= bad_next;
    end
  end

  assign key.valid            = out_valid;
  assign key.key_code         = out_code;
  assign key.released         = out_rel;
  assign key.pattern_mismatch = out_bad;

endmodule
